### src/scfr_pkg.sv
package scfr_pkg;

	localparam int unsigned PAYLOAD_CAPACITY = 4096;

	localparam logic [7:0] MARK_FRAME = 8'hC0;
	localparam logic [7:0] MARK_ESC   = 8'hDB;
	localparam logic [7:0] ESC_FRAME  = 8'hDC;
	localparam logic [7:0] ESC_ESC    = 8'hDD;

	localparam int unsigned INDEX_W = 12;

	typedef enum logic [4:0] {
		STEP_DIR  = 5'b00001,
		STEP_CMD  = 5'b00010,
		STEP_SIZE = 5'b00100,
		STEP_SUM  = 5'b01000,
		STEP_DATA = 5'b10000
	} step_t;

	typedef struct packed {
		logic [7:0]         frame_direction;
		logic [7:0]         frame_command;
		logic [15:0]        frame_size;
		logic [31:0]        frame_checksum;
		logic [7:0]         payload_byte;
		logic [INDEX_W-1:0] payload_index;
		logic               frame_done;
	} result_t;

endpackage

### src/scfr_if.sv
interface scfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfr_frame_if;
	logic                        valid;
	logic                        ready;
	logic [7:0]                  frame_direction;
	logic [7:0]                  frame_command;
	logic [15:0]                 frame_size;
	logic [31:0]                 frame_checksum;
	logic [7:0]                  payload_byte;
	logic [scfr_pkg::INDEX_W-1:0] payload_index;
	logic                        frame_done;

	modport source (
		output valid, output frame_direction, output frame_command, output frame_size,
		output frame_checksum, output payload_byte, output payload_index,
		output frame_done, input ready
	);
	modport sink (
		input valid, input frame_direction, input frame_command, input frame_size,
		input frame_checksum, input payload_byte, input payload_index,
		input frame_done, output ready
	);
endinterface

### src/scfr_in_stage.sv
module scfr_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	scfr_byte_if.sink  rx,
	input  logic       adv,
	output logic       vld_s1,
	output logic [7:0] byte_s1
);

	logic take;

	assign rx.ready = !vld_s1 || adv;
	assign take     = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

### src/scfr_parser.sv
module scfr_parser #(
	parameter int unsigned PAYLOAD_CAPACITY = scfr_pkg::PAYLOAD_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        byte_s1,
	output logic              res_vld,
	output scfr_pkg::result_t res
);

	localparam int unsigned CNT_W = $clog2(PAYLOAD_CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP = CNT_W'(PAYLOAD_CAPACITY);

	scfr_pkg::step_t  step_q;
	logic             esc_q;
	logic [1:0]       size_cnt_q;
	logic [2:0]       sum_cnt_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       dir_q;
	logic [7:0]       cmd_q;
	logic [15:0]      size_q;
	logic [31:0]      sum_q;

	logic             is_frame;
	logic             is_esc;
	logic             is_data;
	logic [7:0]       b;
	logic [15:0]      pos16;
	logic [15:0]      next16;
	logic             below_cap;
	logic             below_size;

	assign is_frame = (byte_s1 == scfr_pkg::MARK_FRAME);
	assign is_esc   = (byte_s1 == scfr_pkg::MARK_ESC);
	assign is_data  = fire && !is_frame && !is_esc;

	always_comb begin
		b = byte_s1;
		if (esc_q && byte_s1 == scfr_pkg::ESC_FRAME) begin
			b = scfr_pkg::MARK_FRAME;
		end else if (esc_q && byte_s1 == scfr_pkg::ESC_ESC) begin
			b = scfr_pkg::MARK_ESC;
		end
	end

	// pos stays below capacity (at most 65535) whenever next16 is used
	assign pos16      = 16'(cnt_q);
	assign next16     = pos16 + 16'd1;
	assign below_cap  = (cnt_q != CAP);
	assign below_size = (pos16 < size_q);

	assign res_vld = is_data && (step_q == scfr_pkg::STEP_DATA) && below_cap && below_size;

	assign res.frame_direction = dir_q;
	assign res.frame_command   = cmd_q;
	assign res.frame_size      = size_q;
	assign res.frame_checksum  = sum_q;
	assign res.payload_byte    = b;
	assign res.payload_index   = scfr_pkg::INDEX_W'(cnt_q);
	assign res.frame_done      = (next16 == size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= scfr_pkg::STEP_DIR;
			esc_q      <= 1'b0;
			size_cnt_q <= '0;
			sum_cnt_q  <= '0;
			cnt_q      <= '0;
			dir_q      <= '0;
			cmd_q      <= '0;
			size_q     <= '0;
			sum_q      <= '0;
		end else if (fire) begin
			if (is_frame) begin
				step_q     <= scfr_pkg::STEP_DIR;
				esc_q      <= 1'b0;
				size_cnt_q <= '0;
				sum_cnt_q  <= '0;
				cnt_q      <= '0;
			end else if (is_esc) begin
				esc_q <= 1'b1;
			end else begin
				esc_q <= 1'b0;
				case (step_q)
					scfr_pkg::STEP_DIR: begin
						dir_q  <= b;
						step_q <= scfr_pkg::STEP_CMD;
					end
					scfr_pkg::STEP_CMD: begin
						cmd_q  <= b;
						step_q <= scfr_pkg::STEP_SIZE;
					end
					scfr_pkg::STEP_SIZE: begin
						if (size_cnt_q == 2'd0) begin
							size_q <= {8'h00, b};
						end else begin
							size_q <= size_q | {b, 8'h00};
						end
						size_cnt_q <= size_cnt_q + 2'd1;
						if (size_cnt_q == 2'd1) begin
							step_q <= scfr_pkg::STEP_SUM;
						end
					end
					scfr_pkg::STEP_SUM: begin
						if (sum_cnt_q == 3'd0) begin
							sum_q <= {24'h0, b};
						end else begin
							sum_q <= sum_q | (32'(b) << {sum_cnt_q[1:0], 3'b000});
						end
						sum_cnt_q <= sum_cnt_q + 3'd1;
						if (sum_cnt_q == 3'd3) begin
							step_q <= scfr_pkg::STEP_DATA;
						end
					end
					scfr_pkg::STEP_DATA: begin
						if (below_cap) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_marker_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_frame |=> step_q == scfr_pkg::STEP_DIR && cnt_q == '0 && !esc_q)
		else $error("frame marker did not restart parse");

	a_count_advances: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("payload count did not advance on a result");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP)
		else $error("payload count past capacity");

	a_result_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> step_q == scfr_pkg::STEP_DATA && size_q != 16'd0)
		else $error("result outside payload step");
`endif

endmodule

### src/scfr_out_reg.sv
module scfr_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_vld,
	input  scfr_pkg::result_t res,
	output logic              adv,
	scfr_frame_if.source      frame
);

	logic              vld_q;
	scfr_pkg::result_t res_q;

	assign adv = !vld_q || frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_vld) begin
			res_q <= res;
		end
	end

	assign frame.valid           = vld_q;
	assign frame.frame_direction = res_q.frame_direction;
	assign frame.frame_command   = res_q.frame_command;
	assign frame.frame_size      = res_q.frame_size;
	assign frame.frame_checksum  = res_q.frame_checksum;
	assign frame.payload_byte    = res_q.payload_byte;
	assign frame.payload_index   = res_q.payload_index;
	assign frame.frame_done      = res_q.frame_done;

endmodule

### src/slip_command_frame_receiver.sv
// A payload byte is taken into the input register, parsed combinationally and
// presented as a valid result from the result register.
// Throughput: one byte per cycle while the result side is ready; the parse state
// updates together with the result register, from the input register.
// Reset (arst_n low, asynchronous): parse restarts expecting a direction byte,
// counts and held header fields clear, both registers empty.
module slip_command_frame_receiver #(
	parameter int unsigned PAYLOAD_CAPACITY = scfr_pkg::PAYLOAD_CAPACITY
) (
	input  logic         clk,
	input  logic         arst_n,
	scfr_byte_if.sink    rx,
	scfr_frame_if.source frame
);

	logic              adv;
	logic              vld_s1;
	logic [7:0]        byte_s1;
	logic              fire;
	logic              res_vld;
	scfr_pkg::result_t res;

	assign fire = vld_s1 && adv;

	scfr_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.adv     (adv),
		.vld_s1  (vld_s1),
		.byte_s1 (byte_s1)
	);

	scfr_parser #(
		.PAYLOAD_CAPACITY (PAYLOAD_CAPACITY)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.res_vld (res_vld),
		.res     (res)
	);

	scfr_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.res_vld (res_vld),
		.res     (res),
		.adv     (adv),
		.frame   (frame)
	);

endmodule

### verif/scfr_checker.sv
`timescale 1ns / 1ps

module scfr_checker (
	input  logic        clk,
	input  logic        arst_n,
	scfr_byte_if        rx,
	scfr_frame_if       frame,
	output int unsigned failures,
	output int unsigned pending,
	output int unsigned checked
);

	// Parse state, mirrors the receiver
	scfr_pkg::step_t step;
	logic            esc_armed;
	logic [1:0]      size_cnt;
	logic [2:0]      sum_cnt;
	logic [12:0]     byte_count;
	logic [7:0]      hdr_dir;
	logic [7:0]      hdr_cmd;
	logic [15:0]     hdr_size;
	logic [31:0]     hdr_sum;

	scfr_pkg::result_t expected_payload[$];

	task automatic report(input string msg);
		failures++;
		$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	task automatic restart_parse();
		esc_armed  = 1'b0;
		step       = scfr_pkg::STEP_DIR;
		size_cnt   = '0;
		sum_cnt    = '0;
		byte_count = '0;
	endtask

	task automatic decode_rx_byte(input logic [7:0] raw);
		logic [7:0]        b;
		logic [12:0]       pos;
		scfr_pkg::result_t r;
		b = raw;
		if (b == scfr_pkg::MARK_FRAME) begin
			restart_parse();
			return;
		end
		if (b == scfr_pkg::MARK_ESC) begin
			esc_armed = 1'b1;
			return;
		end
		if (esc_armed) begin
			if (b == scfr_pkg::ESC_FRAME)
				b = scfr_pkg::MARK_FRAME;
			else if (b == scfr_pkg::ESC_ESC)
				b = scfr_pkg::MARK_ESC;
			esc_armed = 1'b0;
		end
		case (step)
			scfr_pkg::STEP_DIR: begin
				hdr_dir = b;
				step    = scfr_pkg::STEP_CMD;
			end
			scfr_pkg::STEP_CMD: begin
				hdr_cmd = b;
				step    = scfr_pkg::STEP_SIZE;
			end
			scfr_pkg::STEP_SIZE: begin
				if (size_cnt == 0)
					hdr_size = {8'h00, b};
				else
					hdr_size[15:8] = b;
				size_cnt++;
				if (size_cnt == 2)
					step = scfr_pkg::STEP_SUM;
			end
			scfr_pkg::STEP_SUM: begin
				if (sum_cnt == 0)
					hdr_sum = {24'h0, b};
				else
					hdr_sum |= 32'(b) << (8 * sum_cnt[1:0]);
				sum_cnt++;
				if (sum_cnt == 4)
					step = scfr_pkg::STEP_DATA;
			end
			scfr_pkg::STEP_DATA: begin
				pos = byte_count;
				// count saturates at capacity
				if (pos >= scfr_pkg::PAYLOAD_CAPACITY)
					return;
				byte_count = pos + 1'b1;
				if (16'(pos) >= hdr_size)
					return;
				r.frame_direction = hdr_dir;
				r.frame_command   = hdr_cmd;
				r.frame_size      = hdr_size;
				r.frame_checksum  = hdr_sum;
				r.payload_byte    = b;
				r.payload_index   = pos[scfr_pkg::INDEX_W-1:0];
				r.frame_done      = (16'(byte_count) == hdr_size);
				expected_payload.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want, input logic [scfr_pkg::INDEX_W-1:0] idx);
		if (got !== want)
			report($sformatf("%s got %0h expected %0h (index %0d)", name, got, want, idx));
	endtask

	task automatic check_transfer();
		scfr_pkg::result_t want;
		if (expected_payload.size() == 0) begin
			report($sformatf("transfer with nothing expected, byte %0h index %0d",
				frame.payload_byte, frame.payload_index));
			return;
		end
		want = expected_payload.pop_front();
		checked++;
		compare_field("frame_direction", 32'(frame.frame_direction),
			32'(want.frame_direction), want.payload_index);
		compare_field("frame_command", 32'(frame.frame_command),
			32'(want.frame_command), want.payload_index);
		compare_field("frame_size", 32'(frame.frame_size), 32'(want.frame_size),
			want.payload_index);
		compare_field("frame_checksum", frame.frame_checksum, want.frame_checksum,
			want.payload_index);
		compare_field("payload_byte", 32'(frame.payload_byte), 32'(want.payload_byte),
			want.payload_index);
		compare_field("payload_index", 32'(frame.payload_index), 32'(want.payload_index),
			want.payload_index);
		compare_field("frame_done", 32'(frame.frame_done), 32'(want.frame_done),
			want.payload_index);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_parse();
			hdr_dir  = '0;
			hdr_cmd  = '0;
			hdr_size = '0;
			hdr_sum  = '0;
			expected_payload.delete();
			pending = 0;
		end else begin
			if (frame.valid === 1'b1 && frame.ready === 1'b1)
				check_transfer();
			if (rx.valid === 1'b1 && rx.ready === 1'b1)
				decode_rx_byte(rx.rx_byte);
			pending = expected_payload.size();
		end
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	logic clk = 1'b0;
	logic arst_n;

	scfr_byte_if  rx_chan ();
	scfr_frame_if frame_chan ();

	int unsigned failures;
	int unsigned pending;
	int unsigned checked;

	int unsigned bytes_sent  = 0;
	int unsigned frames_sent = 0;
	int unsigned gap_odds    = 10;
	int unsigned stall_left  = 0;
	bit          calm        = 1'b0;
	bit          big_done    = 1'b0;

	slip_command_frame_receiver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_chan),
		.frame  (frame_chan)
	);

	scfr_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_chan),
		.frame    (frame_chan),
		.failures (failures),
		.pending  (pending),
		.checked  (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side backpressure: random stall bursts, none once calm
	always @(posedge clk) begin
		if (calm) begin
			frame_chan.ready <= 1'b1;
			stall_left       <= 0;
		end else if (stall_left != 0) begin
			frame_chan.ready <= 1'b0;
			stall_left       <= stall_left - 1;
		end else if ($urandom_range(0, 11) == 0) begin
			frame_chan.ready <= 1'b0;
			stall_left       <= $urandom_range(0, 14);
		end else begin
			frame_chan.ready <= 1'b1;
		end
	end

	initial begin
		#25_000_000;
		$display("timeout: %0d results still expected", pending);
		$display("** slip_command_frame_receiver: FAILED **");
		$finish;
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return scfr_pkg::MARK_FRAME;
			1: return scfr_pkg::MARK_ESC;
			2: return scfr_pkg::ESC_FRAME;
			3: return scfr_pkg::ESC_ESC;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b);
		if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			rx_chan.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		rx_chan.valid   <= 1'b1;
		rx_chan.rx_byte <= b;
		do @(posedge clk); while (rx_chan.ready !== 1'b1);
		bytes_sent++;
	endtask

	// SLIP-encode one data byte; sometimes uses a redundant or unknown escape
	task automatic send_stuffed(input logic [7:0] b);
		if (b == scfr_pkg::MARK_FRAME) begin
			send_byte(scfr_pkg::MARK_ESC);
			send_byte(scfr_pkg::ESC_FRAME);
		end else if (b == scfr_pkg::MARK_ESC) begin
			send_byte(scfr_pkg::MARK_ESC);
			if ($urandom_range(0, 9) == 0)
				send_byte(scfr_pkg::MARK_ESC);
			send_byte(scfr_pkg::ESC_ESC);
		end else if (b != scfr_pkg::ESC_FRAME && b != scfr_pkg::ESC_ESC &&
				$urandom_range(0, 19) == 0) begin
			send_byte(scfr_pkg::MARK_ESC);
			send_byte(b);
		end else begin
			send_byte(b);
		end
	endtask

	task automatic send_frame(input logic [15:0] size, input int unsigned payload_len);
		logic [31:0] sum;
		sum = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
		send_byte(scfr_pkg::MARK_FRAME);
		if ($urandom_range(0, 9) == 0)
			send_byte(scfr_pkg::MARK_FRAME);
		send_stuffed(pick_byte());
		send_stuffed(pick_byte());
		send_stuffed(size[7:0]);
		send_stuffed(size[15:8]);
		for (int i = 0; i < 4; i++)
			send_stuffed(sum[8*i +: 8]);
		for (int unsigned i = 0; i < payload_len; i++)
			send_stuffed(pick_byte());
		frames_sent++;
	endtask

	task automatic drain();
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned   directed_bytes;
		int unsigned   kind;
		int unsigned   len;
		logic [15:0]   size;
		arst_n           = 1'b0;
		rx_chan.valid    = 1'b0;
		rx_chan.rx_byte  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: header with escaped fields, direction 00, command FF, size 2
		send_byte(scfr_pkg::MARK_FRAME);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(scfr_pkg::MARK_ESC);
		send_byte(scfr_pkg::ESC_FRAME);
		send_byte(scfr_pkg::MARK_ESC);
		send_byte(scfr_pkg::ESC_ESC);
		send_byte(8'hFF);
		send_byte(8'h00);
		// unknown escape passes the byte through
		send_byte(scfr_pkg::MARK_ESC);
		send_byte(8'h41);
		// repeated escape stays armed; completes the frame
		send_byte(scfr_pkg::MARK_ESC);
		send_byte(scfr_pkg::MARK_ESC);
		send_byte(scfr_pkg::ESC_ESC);
		// past declared size: no transfer
		send_byte(8'h55);
		// zero-size frame never completes
		send_byte(scfr_pkg::MARK_FRAME);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'h00);
		repeat (4) send_byte(8'h00);
		send_byte(8'h77);
		frames_sent += 2;
		directed_bytes = bytes_sent;
		drain();

		while (bytes_sent - directed_bytes < 1700) begin
			case ($urandom_range(0, 2))
				0: gap_odds = 0;
				1: gap_odds = 4;
				default: gap_odds = 12;
			endcase
			if (bytes_sent - directed_bytes > 1400)
				calm = 1'b1;
			if (!big_done && bytes_sent - directed_bytes > 700) begin
				// hold off until the block has caught up, then a frame declaring
				// far more than it carries
				rx_chan.valid <= 1'b0;
				drain();
				send_frame(16'hFFFF, $urandom_range(40, 120));
				big_done = 1'b1;
				continue;
			end
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				case ($urandom_range(0, 19))
					0: size = 16'h0000;
					1, 2: size = 16'($urandom_range(17, 300));
					default: size = 16'($urandom_range(1, 16));
				endcase
				len = {16'h0000, size};
				case ($urandom_range(0, 7))
					0: len = size + $urandom_range(1, 3);
					1: len = $urandom_range(0, size);
					default: ;
				endcase
				send_frame(size, len);
			end else if (kind < 17) begin
				send_byte(scfr_pkg::MARK_FRAME);
				repeat ($urandom_range(0, 7)) send_stuffed(pick_byte());
			end else begin
				repeat ($urandom_range(1, 8)) send_byte(pick_byte());
			end
		end

		rx_chan.valid <= 1'b0;
		calm = 1'b1;
		drain();

		$display("sent %0d bytes in %0d frames plus noise, incl. one frame declaring 0xFFFF bytes",
			bytes_sent, frames_sent);
		$display("checked %0d payload transfers", checked);
		if (failures == 0 && pending == 0)
			$display("** slip_command_frame_receiver: PASSED **");
		else
			$display("** slip_command_frame_receiver: FAILED **");
		$finish;
	end

endmodule

### files.f
src/scfr_pkg.sv
src/scfr_if.sv
src/scfr_in_stage.sv
src/scfr_parser.sv
src/scfr_out_reg.sv
src/slip_command_frame_receiver.sv
verif/scfr_checker.sv
verif/tb_top.sv
